@@ hdl/sswf_pkg.sv @@
package sswf_pkg;

  localparam int STEP_W = 5;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_PACKET_KIND     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SERVO_COUNT     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BROADCAST_ID    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_OPCODE     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GOAL_ADDRESS    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TORQUE_ADDRESS  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TORQUE_ON       = 3'd6;

  localparam logic [15:0] CRC_POLY = 16'h8005;
  localparam logic [7:0] SYNC_FF = 8'hff;
  localparam logic [7:0] SYNC_FD = 8'hfd;
  localparam logic [7:0] SYNC_00 = 8'h00;
  localparam logic [7:0] LEN_BASE = 8'd7;

  // microprogram step addresses
  localparam logic [STEP_W-1:0] ST_WAIT   = 5'd0;
  localparam logic [STEP_W-1:0] ST_HDR0   = 5'd1;
  localparam logic [STEP_W-1:0] ST_HDR1   = 5'd2;
  localparam logic [STEP_W-1:0] ST_HDR2   = 5'd3;
  localparam logic [STEP_W-1:0] ST_HDR3   = 5'd4;
  localparam logic [STEP_W-1:0] ST_BID    = 5'd5;
  localparam logic [STEP_W-1:0] ST_LEN_L  = 5'd6;
  localparam logic [STEP_W-1:0] ST_LEN_H  = 5'd7;
  localparam logic [STEP_W-1:0] ST_OPC    = 5'd8;
  localparam logic [STEP_W-1:0] ST_ADDR_L = 5'd9;
  localparam logic [STEP_W-1:0] ST_ADDR_H = 5'd10;
  localparam logic [STEP_W-1:0] ST_DSZ_L  = 5'd11;
  localparam logic [STEP_W-1:0] ST_DSZ_H  = 5'd12;
  localparam logic [STEP_W-1:0] ST_ID     = 5'd13;
  localparam logic [STEP_W-1:0] ST_G0     = 5'd14;
  localparam logic [STEP_W-1:0] ST_G1     = 5'd15;
  localparam logic [STEP_W-1:0] ST_G2     = 5'd16;
  localparam logic [STEP_W-1:0] ST_G3     = 5'd17;
  localparam logic [STEP_W-1:0] ST_TQ     = 5'd18;
  localparam logic [STEP_W-1:0] ST_CRC_L  = 5'd19;
  localparam logic [STEP_W-1:0] ST_CRC_H  = 5'd20;

  typedef enum logic [4:0] {
    SRC_NONE, SRC_FF, SRC_FD, SRC_00, SRC_BID, SRC_LEN_L, SRC_LEN_H, SRC_OPC,
    SRC_ADDR_L, SRC_ADDR_H, SRC_DSZ_L, SRC_DSZ_H, SRC_ID, SRC_G0, SRC_G1,
    SRC_G2, SRC_G3, SRC_TQ, SRC_CRC_L, SRC_CRC_H
  } src_t;

  typedef enum logic [1:0] {
    EOR_NONE, EOR_ALWAYS, EOR_IF_MORE
  } eor_mode_t;

  typedef enum logic [2:0] {
    NXT_SEQ, NXT_GOTO, NXT_TORQUE, NXT_DONE, NXT_WAIT
  } nxt_t;

  typedef struct packed {
    src_t              src;
    logic              emit;
    eor_mode_t         eor;
    logic              eop;
    logic              crc_clear;
    logic              inc;
    nxt_t              nxt;
    logic [STEP_W-1:0] target;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    logic load;
    logic fire;
    src_t src;
    logic eor;
    logic eop;
    logic crc_clear;
  } dp_ctl_t;

  typedef struct packed {
    logic        kind;
    logic [4:0]  count;
    logic [7:0]  bid;
    logic [7:0]  opcode;
    logic [15:0] goal_addr;
    logic [15:0] torque_addr;
    logic        torque_on;
  } cfg_t;

  function automatic uword_t uw(src_t s, eor_mode_t e, logic p, logic c, logic i,
                                nxt_t n, logic [STEP_W-1:0] t);
    uword_t w;
    w.src = s;
    w.emit = (s != SRC_NONE);
    w.eor = e;
    w.eop = p;
    w.crc_clear = c;
    w.inc = i;
    w.nxt = n;
    w.target = t;
    return w;
  endfunction

  function automatic uword_t ucode(logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      ST_WAIT:   w = uw(SRC_NONE, EOR_NONE, 1'b0, 1'b0, 1'b0, NXT_WAIT, ST_ID);
      ST_HDR0:   w = uw(SRC_FF, EOR_NONE, 1'b0, 1'b0, 1'b0, NXT_SEQ, ST_WAIT);
      ST_HDR1:   w = uw(SRC_FF, EOR_NONE, 1'b0, 1'b0, 1'b0, NXT_SEQ, ST_WAIT);
      ST_HDR2:   w = uw(SRC_FD, EOR_NONE, 1'b0, 1'b0, 1'b0, NXT_SEQ, ST_WAIT);
      ST_HDR3:   w = uw(SRC_00, EOR_NONE, 1'b0, 1'b0, 1'b0, NXT_SEQ, ST_WAIT);
      ST_BID:    w = uw(SRC_BID, EOR_NONE, 1'b0, 1'b0, 1'b0, NXT_SEQ, ST_WAIT);
      ST_LEN_L:  w = uw(SRC_LEN_L, EOR_NONE, 1'b0, 1'b0, 1'b0, NXT_SEQ, ST_WAIT);
      ST_LEN_H:  w = uw(SRC_LEN_H, EOR_NONE, 1'b0, 1'b0, 1'b0, NXT_SEQ, ST_WAIT);
      ST_OPC:    w = uw(SRC_OPC, EOR_NONE, 1'b0, 1'b0, 1'b0, NXT_SEQ, ST_WAIT);
      ST_ADDR_L: w = uw(SRC_ADDR_L, EOR_NONE, 1'b0, 1'b0, 1'b0, NXT_SEQ, ST_WAIT);
      ST_ADDR_H: w = uw(SRC_ADDR_H, EOR_NONE, 1'b0, 1'b0, 1'b0, NXT_SEQ, ST_WAIT);
      ST_DSZ_L:  w = uw(SRC_DSZ_L, EOR_NONE, 1'b0, 1'b0, 1'b0, NXT_SEQ, ST_WAIT);
      ST_DSZ_H:  w = uw(SRC_DSZ_H, EOR_NONE, 1'b0, 1'b0, 1'b0, NXT_SEQ, ST_WAIT);
      ST_ID:     w = uw(SRC_ID, EOR_NONE, 1'b0, 1'b0, 1'b0, NXT_TORQUE, ST_TQ);
      ST_G0:     w = uw(SRC_G0, EOR_NONE, 1'b0, 1'b0, 1'b0, NXT_SEQ, ST_WAIT);
      ST_G1:     w = uw(SRC_G1, EOR_NONE, 1'b0, 1'b0, 1'b0, NXT_SEQ, ST_WAIT);
      ST_G2:     w = uw(SRC_G2, EOR_NONE, 1'b0, 1'b0, 1'b0, NXT_SEQ, ST_WAIT);
      ST_G3:     w = uw(SRC_G3, EOR_IF_MORE, 1'b0, 1'b0, 1'b1, NXT_DONE, ST_CRC_L);
      ST_TQ:     w = uw(SRC_TQ, EOR_IF_MORE, 1'b0, 1'b0, 1'b1, NXT_DONE, ST_CRC_L);
      ST_CRC_L:  w = uw(SRC_CRC_L, EOR_NONE, 1'b0, 1'b0, 1'b0, NXT_SEQ, ST_WAIT);
      ST_CRC_H:  w = uw(SRC_CRC_H, EOR_ALWAYS, 1'b1, 1'b1, 1'b0, NXT_GOTO, ST_WAIT);
      default:   w = uw(SRC_NONE, EOR_NONE, 1'b0, 1'b0, 1'b0, NXT_GOTO, ST_WAIT);
    endcase
    return w;
  endfunction

  // msb-first crc-16, one byte
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ hdl/sswf_if.sv @@
interface sswf_entry_if;
  logic        valid;
  logic        ready;
  logic [7:0]  servo_id;
  logic [31:0] goal_value;

  modport source (output valid, output servo_id, output goal_value, input ready);
  modport sink (input valid, input servo_id, input goal_value, output ready);
endinterface

interface sswf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_run;
  logic       end_of_packet;

  modport source (output valid, output out_byte, output end_of_run,
                  output end_of_packet, input ready);
  modport sink (input valid, input out_byte, input end_of_run,
                input end_of_packet, output ready);
endinterface

@@ hdl/sswf_sequencer.sv @@
module sswf_sequencer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   out_free,
  input  logic                   kind,
  input  logic [4:0]             count,
  output sswf_pkg::dp_ctl_t      ctl
);

  logic [sswf_pkg::STEP_W-1:0] step, step_next;
  logic [4:0] entries, entries_next;
  sswf_pkg::uword_t word;
  logic advance;
  logic accept;
  logic pkt_done;

  assign word = sswf_pkg::ucode(step);
  assign in_ready = (word.nxt == sswf_pkg::NXT_WAIT);
  assign accept = in_ready && in_valid;
  assign advance = in_ready ? accept : (!word.emit || out_free);

  // this entry completes the packet
  assign pkt_done = ({1'b0, entries} + 6'd1) >= {1'b0, count};

  always_comb begin
    step_next = step + 5'd1;
    case (word.nxt)
      sswf_pkg::NXT_SEQ:    step_next = step + 5'd1;
      sswf_pkg::NXT_GOTO:   step_next = word.target;
      sswf_pkg::NXT_TORQUE: step_next = kind ? word.target : step + 5'd1;
      sswf_pkg::NXT_DONE:   step_next = pkt_done ? word.target : sswf_pkg::ST_WAIT;
      sswf_pkg::NXT_WAIT:   step_next = (entries == 5'd0) ? step + 5'd1 : word.target;
      default:              step_next = sswf_pkg::ST_WAIT;
    endcase
  end

  always_comb begin
    entries_next = entries;
    if (advance && word.inc) entries_next = pkt_done ? 5'd0 : entries + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= sswf_pkg::ST_WAIT;
      entries <= 5'd0;
    end else begin
      if (advance) step <= step_next;
      entries <= entries_next;
    end
  end

  always_comb begin
    ctl.load = accept;
    ctl.fire = advance && word.emit;
    ctl.src = word.src;
    ctl.eor = (word.eor == sswf_pkg::EOR_ALWAYS) ||
              ((word.eor == sswf_pkg::EOR_IF_MORE) && !pkt_done);
    ctl.eop = word.eop;
    ctl.crc_clear = word.crc_clear;
  end

endmodule

@@ hdl/sswf_datapath.sv @@
module sswf_datapath (
  input  logic               clk,
  input  logic               rst,
  input  sswf_pkg::dp_ctl_t  ctl,
  input  sswf_pkg::cfg_t     cfg,
  input  logic [7:0]         servo_id,
  input  logic [31:0]        goal_value,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_free,
  output logic [7:0]         out_byte,
  output logic               end_of_run,
  output logic               end_of_packet
);

  logic [7:0]  id_q;
  logic [31:0] goal_q;
  logic [15:0] crc;
  logic [15:0] len;
  logic [15:0] addr;
  logic [15:0] dsize;
  logic [7:0]  byte_sel;

  assign len = 16'(sswf_pkg::LEN_BASE) +
               (cfg.kind ? 16'({cfg.count, 1'b0})
                         : 16'({cfg.count, 2'b00}) + 16'(cfg.count));
  assign addr = cfg.kind ? cfg.torque_addr : cfg.goal_addr;
  assign dsize = cfg.kind ? 16'd1 : 16'd4;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    case (ctl.src)
      sswf_pkg::SRC_FF:     byte_sel = sswf_pkg::SYNC_FF;
      sswf_pkg::SRC_FD:     byte_sel = sswf_pkg::SYNC_FD;
      sswf_pkg::SRC_00:     byte_sel = sswf_pkg::SYNC_00;
      sswf_pkg::SRC_BID:    byte_sel = cfg.bid;
      sswf_pkg::SRC_LEN_L:  byte_sel = len[7:0];
      sswf_pkg::SRC_LEN_H:  byte_sel = len[15:8];
      sswf_pkg::SRC_OPC:    byte_sel = cfg.opcode;
      sswf_pkg::SRC_ADDR_L: byte_sel = addr[7:0];
      sswf_pkg::SRC_ADDR_H: byte_sel = addr[15:8];
      sswf_pkg::SRC_DSZ_L:  byte_sel = dsize[7:0];
      sswf_pkg::SRC_DSZ_H:  byte_sel = dsize[15:8];
      sswf_pkg::SRC_ID:     byte_sel = id_q;
      sswf_pkg::SRC_G0:     byte_sel = goal_q[7:0];
      sswf_pkg::SRC_G1:     byte_sel = goal_q[15:8];
      sswf_pkg::SRC_G2:     byte_sel = goal_q[23:16];
      sswf_pkg::SRC_G3:     byte_sel = goal_q[31:24];
      sswf_pkg::SRC_TQ:     byte_sel = {7'd0, cfg.torque_on};
      sswf_pkg::SRC_CRC_L:  byte_sel = crc[7:0];
      sswf_pkg::SRC_CRC_H:  byte_sel = crc[15:8];
      default:              byte_sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      id_q <= servo_id;
      goal_q <= goal_value;
    end
    if (ctl.fire) begin
      out_byte <= byte_sel;
      end_of_run <= ctl.eor;
      end_of_packet <= ctl.eop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      crc <= 16'd0;
    end else begin
      if (ctl.fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      // crc holds while its own low byte goes out
      if (ctl.fire) begin
        if (ctl.crc_clear) crc <= 16'd0;
        else if (ctl.src != sswf_pkg::SRC_CRC_L) crc <= sswf_pkg::crc_byte(crc, byte_sel);
      end
    end
  end

endmodule

@@ hdl/servo_sync_write_framer.sv @@
// on acceptance the step register moves on, then the first byte loads the output register
// throughput: one byte per cycle from the step counter unless the output stalls, plus one
//   wait step per entry; the first entry adds the header bytes, the last adds two crc bytes
// a stalled output register holds the sequencer on the current step
// reset (rst, synchronous, active high) restores register defaults, clears crc and entries
module servo_sync_write_framer #(
  parameter int MAX_SERVOS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [sswf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sswf_pkg::CFG_DATA_W-1:0]    cfg_data,
  sswf_entry_if.sink                         entry,
  sswf_byte_if.source                        stream
);

  // configuration registers
  logic        packet_kind;
  logic [4:0]  servo_count;
  logic [7:0]  broadcast_id;
  logic [7:0]  sync_write_opcode;
  logic [15:0] goal_table_address;
  logic [15:0] torque_table_address;
  logic        torque_on;

  logic [4:0] count_eff;
  sswf_pkg::cfg_t cfg;
  sswf_pkg::dp_ctl_t ctl;
  logic out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_kind <= 1'b0;
      servo_count <= 5'd1;
      broadcast_id <= 8'd254;
      sync_write_opcode <= 8'd131;
      goal_table_address <= 16'd116;
      torque_table_address <= 16'd64;
      torque_on <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sswf_pkg::REG_PACKET_KIND:    packet_kind <= cfg_data[0];
        sswf_pkg::REG_SERVO_COUNT:    servo_count <= cfg_data[4:0];
        sswf_pkg::REG_BROADCAST_ID:   broadcast_id <= cfg_data[7:0];
        sswf_pkg::REG_SYNC_OPCODE:    sync_write_opcode <= cfg_data[7:0];
        sswf_pkg::REG_GOAL_ADDRESS:   goal_table_address <= cfg_data;
        sswf_pkg::REG_TORQUE_ADDRESS: torque_table_address <= cfg_data;
        sswf_pkg::REG_TORQUE_ON:      torque_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // a zero count acts as one, and the count is capped at the servo maximum
  always_comb begin
    if (servo_count == 5'd0) count_eff = 5'd1;
    else if ({3'd0, servo_count} > 8'(MAX_SERVOS)) count_eff = 5'(MAX_SERVOS);
    else count_eff = servo_count;
  end

  always_comb begin
    cfg.kind = packet_kind;
    cfg.count = count_eff;
    cfg.bid = broadcast_id;
    cfg.opcode = sync_write_opcode;
    cfg.goal_addr = goal_table_address;
    cfg.torque_addr = torque_table_address;
    cfg.torque_on = torque_on;
  end

  // step counter and microprogram table
  sswf_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (entry.valid),
    .in_ready (entry.ready),
    .out_free (out_free),
    .kind     (packet_kind),
    .count    (count_eff),
    .ctl      (ctl)
  );

  // byte select, running crc and the output register
  sswf_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .cfg           (cfg),
    .servo_id      (entry.servo_id),
    .goal_value    (entry.goal_value),
    .out_ready     (stream.ready),
    .out_valid     (stream.valid),
    .out_free      (out_free),
    .out_byte      (stream.out_byte),
    .end_of_run    (stream.end_of_run),
    .end_of_packet (stream.end_of_packet)
  );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import sswf_pkg::*;

  localparam int MAX_SERVOS = 16;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES = 150;
  localparam int RANDOM_ITEMS = 185;
  // index 7 is not decoded by the block, writes there must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  // one byte on the wire with its two markers
  typedef struct packed {
    logic [7:0] data;
    logic       eor;
    logic       eop;
  } wire_byte_t;

  typedef enum logic {ROW_REG, ROW_ENTRY} row_kind_t;

  // one row of the directed plan: a register write or a run of servo entries
  typedef struct {
    row_kind_t              what;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  val;
    logic [7:0]             id;
    logic [31:0]            goal;
    int                     copies;     // entries after the first get random content
    int                     typed_len;  // header length field read off by hand, -1 if none
  } plan_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  sswf_entry_if entry_ch ();
  sswf_byte_if  byte_ch ();

  servo_sync_write_framer #(
    .MAX_SERVOS(MAX_SERVOS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .entry    (entry_ch.sink),
    .stream   (byte_ch.source)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: register copy, crc over the packet so far, entries already framed
  cfg_t       shadow;
  logic [15:0] frame_crc;
  logic [4:0]  entries_sent;
  wire_byte_t  fresh[$];          // bytes framed for the entry being accepted
  wire_byte_t  wire_bytes_due[$]; // bytes the block still owes, oldest first

  // run bookkeeping
  int mismatches;
  int bytes_seen;
  int packets_seen;
  int items_sent;
  int settings_used;
  int cycle_count;

  // idling control shared with the receiver process
  bit steady_tx;
  bit steady_rx;
  int hold_requests;
  int holds_granted;
  int hold_left;

  plan_row_t plan[$];

  // crc-16 poly 0x8005, init 0, msb first, fed one bit at a time
  function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0};
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  function automatic void push_wire(logic [7:0] b);
    frame_crc = crc16_next(frame_crc, b);
    fresh.push_back('{data: b, eor: 1'b0, eop: 1'b0});
  endfunction

  // frames one servo entry: header on the first entry, crc after the last
  function automatic void frame_entry(logic [7:0] id, logic [31:0] goal);
    int          cnt;
    int          dsize;
    logic [15:0] len;
    logic [15:0] addr;
    logic [15:0] crc_now;
    cnt = int'(shadow.count);
    if (cnt == 0) cnt = 1;
    if (cnt > MAX_SERVOS) cnt = MAX_SERVOS;
    dsize = shadow.kind ? 1 : 4;
    fresh.delete();
    if (entries_sent == 5'd0) begin
      len = 16'(7 + cnt * (1 + dsize));
      addr = shadow.kind ? shadow.torque_addr : shadow.goal_addr;
      frame_crc = 16'h0000;
      push_wire(SYNC_FF);
      push_wire(SYNC_FF);
      push_wire(SYNC_FD);
      push_wire(SYNC_00);
      push_wire(shadow.bid);
      push_wire(len[7:0]);
      push_wire(len[15:8]);
      push_wire(shadow.opcode);
      push_wire(addr[7:0]);
      push_wire(addr[15:8]);
      push_wire(8'(dsize));
      push_wire(8'h00);
    end
    push_wire(id);
    if (shadow.kind) begin
      push_wire({7'd0, shadow.torque_on});
    end else begin
      for (int k = 0; k < 4; k++) push_wire(goal[8*k +: 8]);
    end
    entries_sent = entries_sent + 5'd1;
    if (int'(entries_sent) >= cnt) begin
      crc_now = frame_crc;
      push_wire(crc_now[7:0]);
      push_wire(crc_now[15:8]);
      fresh[fresh.size()-1].eop = 1'b1;
      frame_crc = 16'h0000;
      entries_sent = 5'd0;
    end
    fresh[fresh.size()-1].eor = 1'b1;
  endfunction

  function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on byte %0d, %s: expected %0h, got %0h", bytes_seen, field, want, got);
  endfunction

  // register write, one cycle with the enable high; the copy is masked like the block
  task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PACKET_KIND:    shadow.kind = val[0];
      REG_SERVO_COUNT:    shadow.count = val[4:0];
      REG_BROADCAST_ID:   shadow.bid = val[7:0];
      REG_SYNC_OPCODE:    shadow.opcode = val[7:0];
      REG_GOAL_ADDRESS:   shadow.goal_addr = val;
      REG_TORQUE_ADDRESS: shadow.torque_addr = val;
      REG_TORQUE_ON:      shadow.torque_on = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // offers one entry, frames it at the accepting edge, then maybe idles the sender
  task automatic offer_entry(logic [7:0] id, logic [31:0] goal, int typed_len);
    logic        starts;
    logic [15:0] tl;
    int          gap;
    entry_ch.valid <= 1'b1;
    entry_ch.servo_id <= id;
    entry_ch.goal_value <= goal;
    do @(posedge clk); while (!entry_ch.ready);
    starts = (entries_sent == 5'd0);
    frame_entry(id, goal);
    // hand-read length replaces the predicted one so both must agree with the wire
    if (starts && typed_len >= 0) begin
      tl = 16'(typed_len);
      fresh[5].data = tl[7:0];
      fresh[6].data = tl[15:8];
    end
    foreach (fresh[i]) wire_bytes_due.push_back(fresh[i]);
    items_sent++;
    if (!steady_tx && $urandom_range(99) < 25) begin
      gap = $urandom_range(1, 4);
      entry_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // block idle: every owed byte out, then a wait for the sequencer to park
  task automatic settle();
    entry_ch.valid <= 1'b0;
    while (wire_bytes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value(int bits);
    logic [15:0] ones;
    int          r;
    ones = 16'((32'd1 << bits) - 1);
    r = $urandom_range(9);
    if (r == 0) return 16'h0000;
    if (r == 1) return ones;
    return 16'($urandom) & ones;
  endfunction

  // narrow registers sometimes get garbage in their unused bits
  function automatic logic [15:0] with_junk(logic [15:0] v, logic [15:0] keep);
    logic [15:0] junk;
    junk = $urandom_range(1) ? 16'($urandom) : 16'h0000;
    return (junk & ~keep) | (v & keep);
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
    plan_row_t r;
    r = '{what: ROW_REG, idx: idx, val: val, id: 8'h00, goal: 32'h0, copies: 0,
          typed_len: -1};
    return r;
  endfunction

  function automatic plan_row_t entry_row(logic [7:0] id, logic [31:0] goal, int copies,
                                          int typed_len);
    plan_row_t r;
    r = '{what: ROW_ENTRY, idx: REG_PACKET_KIND, val: 16'h0, id: id, goal: goal,
          copies: copies, typed_len: typed_len};
    return r;
  endfunction

  // byte receiver: random back-pressure, steady stretches, and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      byte_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_granted < hold_requests) begin
      holds_granted <= holds_granted + 1;
      hold_left <= HOLD_CYCLES - 1;
      byte_ch.ready <= 1'b0;
    end else if (steady_rx) begin
      byte_ch.ready <= 1'b1;
    end else begin
      byte_ch.ready <= ($urandom_range(99) >= 25);
    end
  end

  // each byte transaction is checked against the oldest owed byte, field by field
  always @(posedge clk) begin
    wire_byte_t want;
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      bytes_seen++;
      if (byte_ch.end_of_packet) packets_seen++;
      if (wire_bytes_due.size() == 0) begin
        note_mismatch("unexpected byte", 32'h0, {24'h0, byte_ch.out_byte});
      end else begin
        want = wire_bytes_due.pop_front();
        if (byte_ch.out_byte !== want.data)
          note_mismatch("out_byte", {24'h0, want.data}, {24'h0, byte_ch.out_byte});
        if (byte_ch.end_of_run !== want.eor)
          note_mismatch("end_of_run", {31'h0, want.eor}, {31'h0, byte_ch.end_of_run});
        if (byte_ch.end_of_packet !== want.eop)
          note_mismatch("end_of_packet", {31'h0, want.eop}, {31'h0, byte_ch.end_of_packet});
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d bytes still owed", cycle_count,
               wire_bytes_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int          cnt;
    int          eff;
    int          n;
    int          phase;
    int          stop_at;
    logic        kind;
    bit          busy;
    int          r;

    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_PACKET_KIND;
    cfg_data = '0;
    entry_ch.valid = 1'b0;
    entry_ch.servo_id = 8'h00;
    entry_ch.goal_value = 32'h0;
    byte_ch.ready = 1'b0;
    steady_tx = 1'b0;
    steady_rx = 1'b0;
    hold_requests = 0;
    holds_granted = 0;
    hold_left = 0;
    mismatches = 0;
    bytes_seen = 0;
    packets_seen = 0;
    items_sent = 0;
    settings_used = 1;
    cycle_count = 0;

    // register values after reset
    shadow.kind = 1'b0;
    shadow.count = 5'd1;
    shadow.bid = 8'd254;
    shadow.opcode = 8'd131;
    shadow.goal_addr = 16'd116;
    shadow.torque_addr = 16'd64;
    shadow.torque_on = 1'b0;
    frame_crc = 16'h0000;
    entries_sent = 5'd0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed plan
    // reset settings: one goal entry per packet, extremes of id and goal
    plan.push_back(entry_row(8'h00, 32'h0000_0000, 1, 12));
    plan.push_back(entry_row(8'hff, 32'hffff_ffff, 1, 12));
    // torque packets with the extremes of the header registers
    plan.push_back(reg_row(REG_PACKET_KIND, 16'h0001));
    plan.push_back(reg_row(REG_TORQUE_ON, 16'h0001));
    plan.push_back(reg_row(REG_TORQUE_ADDRESS, 16'hffff));
    plan.push_back(reg_row(REG_BROADCAST_ID, 16'h0000));
    plan.push_back(reg_row(REG_SYNC_OPCODE, 16'h00ff));
    plan.push_back(entry_row(8'h5a, 32'h1234_5678, 1, 9));
    // zero count behaves as one entry per packet
    plan.push_back(reg_row(REG_TORQUE_ON, 16'h0000));
    plan.push_back(reg_row(REG_SERVO_COUNT, 16'h0000));
    plan.push_back(entry_row(8'ha5, 32'h8765_4321, 1, 9));
    // count above the maximum is clamped to sixteen entries
    plan.push_back(reg_row(REG_SERVO_COUNT, 16'h0011));
    plan.push_back(entry_row(8'h01, 32'hdead_beef, 16, 39));
    // goal packet of two, other header extremes, plus a write to the undecoded index
    plan.push_back(reg_row(REG_PACKET_KIND, 16'h0000));
    plan.push_back(reg_row(REG_SERVO_COUNT, 16'h0002));
    plan.push_back(reg_row(REG_GOAL_ADDRESS, 16'h0000));
    plan.push_back(reg_row(REG_BROADCAST_ID, 16'h00ff));
    plan.push_back(reg_row(REG_SYNC_OPCODE, 16'h0000));
    plan.push_back(reg_row(REG_UNUSED, 16'hffff));
    plan.push_back(entry_row(8'h80, 32'h0000_0001, 2, 17));
    // count lowered mid-packet: the header keeps its length, the next entry closes it
    plan.push_back(reg_row(REG_SERVO_COUNT, 16'h0003));
    plan.push_back(entry_row(8'h7f, 32'h8000_0000, 2, 22));
    plan.push_back(reg_row(REG_SERVO_COUNT, 16'h0001));
    plan.push_back(entry_row(8'h3c, 32'h5555_aaaa, 1, -1));

    busy = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].what == ROW_REG) begin
        if (busy) settle();
        busy = 1'b0;
        set_reg(plan[i].idx, plan[i].val);
      end else begin
        busy = 1'b1;
        offer_entry(plan[i].id, plan[i].goal, plan[i].typed_len);
        for (int c = 1; c < plan[i].copies; c++)
          offer_entry(8'($urandom), $urandom, -1);
      end
    end

    // random phases: fresh settings, then whole packets with random content;
    // some phases stop mid-packet so the next settings land inside a packet
    stop_at = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < stop_at) begin
      settle();
      steady_tx = (phase == 2) || (phase == 3);
      steady_rx = (phase == 2);
      kind = 1'($urandom_range(1));
      r = $urandom_range(99);
      if (phase == 3) cnt = 16;
      else if (r < 70) cnt = $urandom_range(1, 4);
      else if (r < 80) cnt = 16;
      else if (r < 88) cnt = 0;
      else cnt = $urandom_range(17, 31);
      set_reg(REG_PACKET_KIND, with_junk(16'(kind), 16'h0001));
      set_reg(REG_SERVO_COUNT, with_junk(16'(cnt), 16'h001f));
      set_reg(REG_BROADCAST_ID, with_junk(pick_value(8), 16'h00ff));
      set_reg(REG_SYNC_OPCODE, with_junk(pick_value(8), 16'h00ff));
      set_reg(REG_GOAL_ADDRESS, pick_value(16));
      set_reg(REG_TORQUE_ADDRESS, pick_value(16));
      set_reg(REG_TORQUE_ON, with_junk(pick_value(1), 16'h0001));
      if ($urandom_range(3) == 0) set_reg(REG_UNUSED, 16'($urandom));
      settings_used++;

      eff = (cnt == 0) ? 1 : ((cnt > MAX_SERVOS) ? MAX_SERVOS : cnt);
      n = eff * ((eff >= 8) ? 1 : $urandom_range(1, 3));
      if (phase != 3 && $urandom_range(4) == 0) n = n + $urandom_range(0, eff - 1);

      // long receiver hold-off while the sender keeps pushing a full packet
      if (phase == 3) hold_requests++;

      for (int k = 0; k < n; k++) offer_entry(8'($urandom), $urandom, -1);
      phase++;
    end

    settle();
    repeat (20) @(posedge clk);

    $display("covered %0d servo entries under %0d register settings", items_sent,
             settings_used);
    $display("checked %0d wire bytes in %0d packets, %0d mismatches", bytes_seen,
             packets_seen, mismatches);
    if (mismatches == 0 && wire_bytes_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ servo_sync_write_framer.f @@
hdl/sswf_pkg.sv
hdl/sswf_if.sv
hdl/sswf_sequencer.sv
hdl/sswf_datapath.sv
hdl/servo_sync_write_framer.sv
bench/testbench.sv
